### hdl/hkr_pkg.sv
// Shared types and constants for the HID keyboard report table.
// No dependencies; used by hkr_slot_cmp and hid_keyboard_report_table.
package hkr_pkg;

  localparam int unsigned SLOT_COUNT = 6;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CODE_W     = 8;

  localparam logic [CODE_W-1:0] EMPTY_SLOT = 8'h00;
  // Modifier usages 0xE0..0xE7 share this upper code prefix
  localparam logic [4:0]        MOD_PREFIX = 5'b11100;

  typedef enum logic [1:0] {
    FUNC_DOWN = 2'd0,
    FUNC_UP   = 2'd1,
    FUNC_ALL  = 2'd2,
    FUNC_RSVD = 2'd3
  } func_e;

  typedef logic [SLOT_COUNT-1:0][CODE_W-1:0] slots_t;

  typedef struct packed {
    logic is_empty;
    logic is_match;
  } cmp_t;

endpackage

### hdl/hkr_slot_cmp.sv
// Shared slot compare unit: select one slot by index, test it for empty and for a code match.
// Depends on hkr_pkg.
module hkr_slot_cmp (
  input  hkr_pkg::slots_t                 slots_i,
  input  logic [hkr_pkg::IDX_W-1:0]       idx_i,
  input  logic [hkr_pkg::CODE_W-1:0]      code_i,
  output hkr_pkg::cmp_t                   cmp_o
);

  logic [hkr_pkg::CODE_W-1:0] slot_val;

  always_comb begin
    // Indexes past the last slot read as empty
    if (idx_i < hkr_pkg::IDX_W'(hkr_pkg::SLOT_COUNT)) begin
      slot_val = slots_i[idx_i];
    end else begin
      slot_val = hkr_pkg::EMPTY_SLOT;
    end
    cmp_o.is_empty = (slot_val == hkr_pkg::EMPTY_SLOT);
    cmp_o.is_match = (slot_val == code_i);
  end

endmodule

### hdl/hid_keyboard_report_table.sv
// Top level of the HID keyboard report table: sequencer, report state and output register.
// Depends on hkr_pkg and hkr_slot_cmp.
//
// Keeps one boot-keyboard report (eight modifier bits, six key slots) and
// applies one key event per input beat. A modifier event (usage 0xE0..0xE7)
// or a release-all goes through accept, apply and load of the output
// register. A key-down or key-up of any other code walks the six slots
// through a single shared compare unit, one slot per cycle, and so goes
// through accept, six scan steps, apply and load. That scan sets
// the rate. The block takes no new event until the current one has either
// loaded its report into the output register or been dropped. A key-down
// that finds its code already in a slot, or finds no empty slot, is dropped
// with no result beat; so is operation code 3. A key-up always yields a
// report, even when no slot matched. The output register holds the finished
// report until it is taken, and the next event may be accepted meanwhile;
// its report waits in the load step while the previous beat is still held.
module hid_keyboard_report_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [hkr_pkg::CODE_W-1:0]  key_code_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  modifier_mask_o,
  output logic [hkr_pkg::CODE_W-1:0]  slot_key_0_o,
  output logic [hkr_pkg::CODE_W-1:0]  slot_key_1_o,
  output logic [hkr_pkg::CODE_W-1:0]  slot_key_2_o,
  output logic [hkr_pkg::CODE_W-1:0]  slot_key_3_o,
  output logic [hkr_pkg::CODE_W-1:0]  slot_key_4_o,
  output logic [hkr_pkg::CODE_W-1:0]  slot_key_5_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  hkr_pkg::func_e               func_q, func_d;
  logic [hkr_pkg::CODE_W-1:0]   code_q, code_d;
  logic [hkr_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic                         free_vld_q, free_vld_d;
  logic [hkr_pkg::IDX_W-1:0]    free_idx_q, free_idx_d;

  // Report state
  logic [7:0]                   mods_q, mods_d;
  hkr_pkg::slots_t              slots_q, slots_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic                         out_load;
  logic [7:0]                   mod_out_q;
  hkr_pkg::slots_t              slot_out_q;

  hkr_pkg::cmp_t                cmp;
  logic                         in_beat;
  logic                         in_is_mod;
  logic                         cur_is_mod;
  logic                         scan_last;

  hkr_slot_cmp u_slot_cmp (
    .slots_i (slots_q),
    .idx_i   (idx_q),
    .code_i  (code_q),
    .cmp_o   (cmp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign in_is_mod  = (key_code_i[7:3] == hkr_pkg::MOD_PREFIX);
  assign cur_is_mod = (code_q[7:3] == hkr_pkg::MOD_PREFIX);
  assign scan_last  = (idx_q == hkr_pkg::IDX_W'(hkr_pkg::SLOT_COUNT - 1));
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    code_d     = code_q;
    idx_d      = idx_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    mods_d     = mods_q;
    slots_d    = slots_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          func_d     = hkr_pkg::func_e'(func_i);
          code_d     = key_code_i;
          idx_d      = '0;
          free_vld_d = 1'b0;
          free_idx_d = '0;
          priority if (hkr_pkg::func_e'(func_i) == hkr_pkg::FUNC_RSVD) begin
            state_d = S_IDLE;       // drop unused operation
          end else if (hkr_pkg::func_e'(func_i) == hkr_pkg::FUNC_ALL || in_is_mod) begin
            state_d = S_APPLY;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        state_d = scan_last ? S_APPLY : S_SCAN;
        idx_d   = idx_q + hkr_pkg::IDX_W'(1);
        if (func_q == hkr_pkg::FUNC_DOWN) begin
          // First empty slot wins; any other slot equal to the code cancels (for code zero, a later empty slot)
          if (!free_vld_q && cmp.is_empty) begin
            free_vld_d = 1'b1;
            free_idx_d = idx_q;
          end else if (cmp.is_match) begin
            state_d = S_IDLE;
          end
        end else if (cmp.is_match) begin
          slots_d[idx_q] = hkr_pkg::EMPTY_SLOT;
        end
      end
      S_APPLY: begin
        state_d = S_EMIT;
        priority if (func_q == hkr_pkg::FUNC_ALL) begin
          mods_d  = '0;
          slots_d = '0;
        end else if (cur_is_mod) begin
          if (func_q == hkr_pkg::FUNC_DOWN) begin
            mods_d[code_q[2:0]] = 1'b1;
          end else begin
            mods_d[code_q[2:0]] = 1'b0;
          end
        end else if (func_q == hkr_pkg::FUNC_DOWN) begin
          if (free_vld_q) begin
            slots_d[free_idx_q] = code_q;
          end else begin
            state_d = S_IDLE;       // no room: drop the event
          end
        end else begin
          state_d = S_EMIT;         // key-up already cleared during the scan
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      free_vld_q  <= 1'b0;
      mods_q      <= '0;
      slots_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      free_vld_q  <= free_vld_d;
      mods_q      <= mods_d;
      slots_q     <= slots_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Event payload and output payload hold no reset
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    code_q     <= code_d;
    free_idx_q <= free_idx_d;
    if (out_load) begin
      mod_out_q  <= mods_q;
      slot_out_q <= slots_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign modifier_mask_o = mod_out_q;
  assign slot_key_0_o    = slot_out_q[0];
  assign slot_key_1_o    = slot_out_q[1];
  assign slot_key_2_o    = slot_out_q[2];
  assign slot_key_3_o    = slot_out_q[3];
  assign slot_key_4_o    = slot_out_q[4];
  assign slot_key_5_o    = slot_out_q[5];

  // An unused operation code is dropped without leaving idle
  a_rsvd_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && func_i == hkr_pkg::FUNC_RSVD) |=> (state_q == S_IDLE))
    else $error("unused operation did not return to idle");

  // Modifier events skip the slot scan
  a_mod_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_is_mod && func_i != hkr_pkg::FUNC_RSVD) |=> (state_q == S_APPLY))
    else $error("modifier event entered the slot scan");

  // Scan index stays within the slot range
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q < hkr_pkg::IDX_W'(hkr_pkg::SLOT_COUNT)))
    else $error("scan index past last slot");

  // A held result beat is never overwritten by the next report
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("report loaded over a pending beat");

endmodule

### test/hkr_report_checker.sv
// Report checker for the HID keyboard report table: watches both channels, tracks the report.
// Depends on hkr_pkg; instantiated by tb_hid_keyboard_report_table beside the block.
`timescale 1ns / 100ps

module hkr_report_checker
  import hkr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        func_i,
  input  logic [CODE_W-1:0] key_code_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        modifier_mask_i,
  input  logic [CODE_W-1:0] slot_key_0_i,
  input  logic [CODE_W-1:0] slot_key_1_i,
  input  logic [CODE_W-1:0] slot_key_2_i,
  input  logic [CODE_W-1:0] slot_key_3_i,
  input  logic [CODE_W-1:0] slot_key_4_i,
  input  logic [CODE_W-1:0] slot_key_5_i,
  output int                fail_count_o,
  output int                pending_reports_o,
  output int                reports_checked_o,
  output int                events_dropped_o
);

  typedef struct {
    logic [7:0] mods;
    slots_t     keys;
  } kbd_report_t;

  logic [7:0]  held_mods;
  slots_t      held_keys;
  kbd_report_t report_q[$];

  // Apply one key event to the tracked report; return 1 when it yields a report.
  function automatic bit apply_key_event(func_e op, logic [CODE_W-1:0] code);
    int  free_idx;
    bit  is_mod;
    free_idx = -1;
    is_mod   = (code[7:3] == MOD_PREFIX);
    case (op)
      FUNC_DOWN: begin
        if (is_mod) begin
          held_mods[code[2:0]] = 1'b1;
          return 1'b1;
        end
        // First empty slot wins; any other slot equal to the code cancels,
        // which for code zero means a second empty slot.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (free_idx < 0 && held_keys[i] == EMPTY_SLOT) free_idx = i;
          else if (held_keys[i] == code) return 1'b0;
        end
        if (free_idx < 0) return 1'b0;
        held_keys[free_idx] = code;
        return 1'b1;
      end
      FUNC_UP: begin
        if (is_mod) begin
          held_mods[code[2:0]] = 1'b0;
        end else begin
          for (int i = 0; i < SLOT_COUNT; i++)
            if (held_keys[i] == code) held_keys[i] = EMPTY_SLOT;
        end
        return 1'b1;
      end
      FUNC_ALL: begin
        held_mods = '0;
        held_keys = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kbd_report_t want;
    slots_t      got_keys;
    int          errs;
    if (!rst_ni) begin
      held_mods = '0;
      held_keys = '0;
      report_q.delete();
      fail_count_o      <= 0;
      pending_reports_o <= 0;
      reports_checked_o <= 0;
      events_dropped_o  <= 0;
    end else begin
      errs = 0;
      if (in_valid_i && in_ready_i) begin
        if (apply_key_event(func_e'(func_i), key_code_i)) begin
          want.mods = held_mods;
          want.keys = held_keys;
          report_q.push_back(want);
        end else begin
          events_dropped_o <= events_dropped_o + 1;
        end
      end
      if (out_valid_i && out_ready_i) begin
        got_keys = {slot_key_5_i, slot_key_4_i, slot_key_3_i,
                    slot_key_2_i, slot_key_1_i, slot_key_0_i};
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report beat: mods %02h keys %h",
                   $time, modifier_mask_i, got_keys);
          errs++;
        end else begin
          want = report_q.pop_front();
          reports_checked_o <= reports_checked_o + 1;
          if (modifier_mask_i !== want.mods) begin
            $display("%0t: modifier_mask mismatch: expected %02h, got %02h",
                     $time, want.mods, modifier_mask_i);
            errs++;
          end
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (got_keys[i] !== want.keys[i]) begin
              $display("%0t: slot_key_%0d mismatch: expected %02h, got %02h",
                       $time, i, want.keys[i], got_keys[i]);
              errs++;
            end
          end
        end
      end
      // Count every mismatch of this beat in one update
      fail_count_o      <= fail_count_o + errs;
      pending_reports_o <= report_q.size();
    end
  end

endmodule

### test/tb_hid_keyboard_report_table.sv
// Testbench top for hid_keyboard_report_table: clock, reset, key event stimulus, verdict.
// Depends on hkr_pkg, the block and hkr_report_checker.
`timescale 1ns / 100ps

module tb_hid_keyboard_report_table;
  import hkr_pkg::*;

  localparam int RANDOM_EVENTS = 1530;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  // Long receiver hold-off: starts this many cycles after reset, lasts this long
  localparam int HOLD_START    = 1500;
  localparam int HOLD_CYCLES   = 300;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        func_i     = FUNC_DOWN;
  logic [CODE_W-1:0] key_code_i = EMPTY_SLOT;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        modifier_mask_o;
  logic [CODE_W-1:0] slot_key_0_o, slot_key_1_o, slot_key_2_o;
  logic [CODE_W-1:0] slot_key_3_o, slot_key_4_o, slot_key_5_o;

  int fail_count, pending_reports, reports_checked, events_dropped;
  int events_sent = 0;
  int cycle_count = 0;

  always #6 clk_i = ~clk_i;

  hid_keyboard_report_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .key_code_i     (key_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .modifier_mask_o(modifier_mask_o),
    .slot_key_0_o   (slot_key_0_o),
    .slot_key_1_o   (slot_key_1_o),
    .slot_key_2_o   (slot_key_2_o),
    .slot_key_3_o   (slot_key_3_o),
    .slot_key_4_o   (slot_key_4_o),
    .slot_key_5_o   (slot_key_5_o)
  );

  // Checker sits beside the block and sees only its ports.
  hkr_report_checker u_report_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .func_i           (func_i),
    .key_code_i       (key_code_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .modifier_mask_i  (modifier_mask_o),
    .slot_key_0_i     (slot_key_0_o),
    .slot_key_1_i     (slot_key_1_o),
    .slot_key_2_i     (slot_key_2_o),
    .slot_key_3_i     (slot_key_3_o),
    .slot_key_4_i     (slot_key_4_o),
    .slot_key_5_i     (slot_key_5_o),
    .fail_count_o     (fail_count),
    .pending_reports_o(pending_reports),
    .reports_checked_o(reports_checked),
    .events_dropped_o (events_dropped)
  );

  // Offer one event at the falling edge and hold it until the beat is taken.
  // A back-to-back call keeps valid high, so valid is never pulsed low.
  task automatic send_event(func_e op, logic [CODE_W-1:0] code);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    events_sent++;
  endtask

  // Drop valid to leave a gap between events.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Mostly key-down and key-up; release-all and the unused code now and then.
  function automatic func_e pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 52) return FUNC_DOWN;
    if (r < 93) return FUNC_UP;
    if (r < 97) return FUNC_ALL;
    return FUNC_RSVD;
  endfunction

  // A small pool of eight keys against six slots keeps the table busy:
  // duplicates, full tables and matching releases happen often. The rest
  // are modifiers, zero, and the full code range for noise.
  function automatic logic [CODE_W-1:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'h04 + 8'($urandom_range(0, 7));
    if (r < 75) return {MOD_PREFIX, 3'($urandom_range(0, 7))};
    if (r < 80) return EMPTY_SLOT;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: rotate through stall patterns, with one long hold-off so the
  // output register and the load step fill and the input gets back-pressured.
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    rx_cycle  = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_cycle / 200) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (rx_cycle % 5 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d reports still expected",
             cycle_count, pending_reports);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned burst_len;
    int          directed_count;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every operation and the corner cases.
    send_event(FUNC_DOWN, 8'h00);   // zero with all slots empty: second empty cancels
    send_event(FUNC_DOWN, 8'hE0);   // lowest modifier
    send_event(FUNC_DOWN, 8'hE7);   // highest modifier
    send_event(FUNC_DOWN, 8'h04);
    send_event(FUNC_DOWN, 8'h04);   // already held: cancelled
    send_event(FUNC_DOWN, 8'hFF);   // top code
    send_event(FUNC_DOWN, 8'hDF);   // just below the modifier range
    send_event(FUNC_DOWN, 8'hE8);   // just above the modifier range
    send_event(FUNC_DOWN, 8'h05);
    send_event(FUNC_DOWN, 8'h06);   // table now full
    send_event(FUNC_DOWN, 8'h07);   // no empty slot: cancelled
    send_event(FUNC_UP,   8'hFF);   // frees slot 1
    send_event(FUNC_DOWN, 8'h00);   // zero with exactly one empty slot: applied
    send_event(FUNC_UP,   8'h55);   // no match, report still sent
    send_event(FUNC_RSVD, 8'hAA);   // unused operation: ignored
    send_event(FUNC_RSVD, 8'h55);
    send_event(FUNC_UP,   8'hE0);
    send_event(FUNC_UP,   8'hE7);
    send_event(FUNC_ALL,  8'hFF);
    send_event(FUNC_DOWN, 8'h08);
    send_event(FUNC_UP,   8'h00);   // key-up of zero with several empty slots
    send_event(FUNC_ALL,  8'h00);
    directed_count = events_sent;

    // Random: bursts of events with random gaps, some bursts back to back.
    while (events_sent < directed_count + RANDOM_EVENTS) begin
      burst_len = $urandom_range(1, 16);
      repeat (burst_len) send_event(pick_func(), pick_code());
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain: wait for all reports, then give a dropped event time to misbehave.
    wait (pending_reports == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d key events (%0d directed), checked %0d reports, %0d events cancelled",
             events_sent, directed_count, reports_checked, events_dropped);
    $display("Receiver held off for %0d cycles once; %0d cycles run in total",
             HOLD_CYCLES, cycle_count);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", fail_count, pending_reports);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
